/* rtl/core/calendar_clock_with_field_edit_top_macros.svh */
// Assertion macros shared by the calendar clock RTL.
`ifndef CALENDAR_CLOCK_WITH_FIELD_EDIT_TOP_MACROS_SVH
`define CALENDAR_CLOCK_WITH_FIELD_EDIT_TOP_MACROS_SVH

// Property that must hold at every clock edge outside reset
`define CCFE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Signal keeps its value in the cycle after a quiet condition
`define CCFE_ASSERT_HOLD(label, quiet, sig, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (quiet) |=> $stable(sig)) \
        else $error(msg);

`endif

/* rtl/core/ccfe_pkg.sv */
// Package with types, codes, constants and helper functions of the calendar clock.
`timescale 1ns / 1ps

package ccfe_pkg;

    // Request kinds
    localparam logic [2:0] MODE_TICK    = 3'd0;
    localparam logic [2:0] MODE_UP      = 3'd1;
    localparam logic [2:0] MODE_DOWN    = 3'd2;
    localparam logic [2:0] MODE_RESTORE = 3'd3;
    localparam logic [2:0] MODE_CAPTURE = 3'd4;

    // Field selector codes
    localparam logic [2:0] FLD_YEAR    = 3'd0;
    localparam logic [2:0] FLD_MONTH   = 3'd1;
    localparam logic [2:0] FLD_DAY     = 3'd2;
    localparam logic [2:0] FLD_HOURS   = 3'd3;
    localparam logic [2:0] FLD_MIN_LO  = 3'd4;
    localparam logic [2:0] FLD_MIN_HI  = 3'd5;
    localparam logic [2:0] FLD_SECONDS = 3'd6;

    // Carry levels of a tick
    localparam logic [1:0] LVL_SEC  = 2'd0;
    localparam logic [1:0] LVL_MIN  = 2'd1;
    localparam logic [1:0] LVL_HOUR = 2'd2;
    localparam logic [1:0] LVL_DAY  = 2'd3;

    // Limits
    localparam logic [5:0]  SEC_TOP   = 6'd59;
    localparam logic [5:0]  HOUR_TOP  = 6'd23;
    localparam logic [3:0]  MONTH_TOP = 4'd12;
    localparam logic [13:0] YEAR_MAX  = 14'd9999;
    localparam logic [8:0]  MOD_TOP   = 9'd399;

    // Reset values; 1962 is 362 within its 400-year cycle
    localparam logic [5:0]  RST_SEC   = 6'd0;
    localparam logic [5:0]  RST_MIN   = 6'd59;
    localparam logic [4:0]  RST_HOUR  = 5'd23;
    localparam logic [4:0]  RST_DAY   = 5'd11;
    localparam logic [3:0]  RST_MONTH = 4'd11;
    localparam logic [13:0] RST_YEAR  = 14'd1962;
    localparam logic [8:0]  RST_YMOD  = 9'd362;

    typedef struct packed {
        logic [2:0] mode;
        logic [2:0] field_select;
    } req_t;

    typedef struct packed {
        logic [5:0]  seconds_out;
        logic [5:0]  minutes_out;
        logic [4:0]  hours_out;
        logic [4:0]  day_out;
        logic [3:0]  month_out;
        logic [13:0] year_out;
        logic [1:0]  carry_level;
        logic        day_rollover;
    } res_t;

    // Gregorian leap test on the year's position in its 400-year cycle
    function automatic logic is_leap(input logic [8:0] ymod);
        return (ymod[1:0] == 2'b00) && (ymod != 9'd100) && (ymod != 9'd200)
            && (ymod != 9'd300);
    endfunction

    // Month length; codes outside 1..12 read 31
    function automatic logic [4:0] month_days(input logic [3:0] mon, input logic leap);
        logic [4:0] n;
        case (mon)
            4'd2:    n = leap ? 5'd29 : 5'd28;
            4'd4:    n = 5'd30;
            4'd6:    n = 5'd30;
            4'd9:    n = 5'd30;
            4'd11:   n = 5'd30;
            default: n = 5'd31;
        endcase
        return n;
    endfunction

    // Day check: past the end gives 1, zero gives the last day
    function automatic logic [4:0] check_day(input logic [5:0] d, input logic [4:0] n);
        logic [4:0] r;
        if (d > {1'b0, n})
            r = 5'd1;
        else if (d == 6'd0)
            r = n;
        else
            r = d[4:0];
        return r;
    endfunction

    // One wrapping step over 0..top
    function automatic logic [5:0] wrap_step(input logic [5:0] v, input logic up,
                                             input logic [5:0] top);
        logic [5:0] r;
        if (up)
            r = (v >= top) ? 6'd0 : v + 6'd1;
        else
            r = ((v == 6'd0) || (v > top)) ? top : v - 6'd1;
        return r;
    endfunction

endpackage

/* rtl/core/calendar_clock_with_field_edit_top.sv */
// Path: a request accepted into the input register passes the calendar update into the result register.
// Throughput: one request per cycle when m_tready is high, set by the single calendar update
// between the input and result registers; the input side takes one request while a result waits.
// Reset: asynchronous, active low; calendar returns to 23:59:00, 11 Nov 1962, snapshot alike.
// Both stages come out of reset empty.
`timescale 1ns / 1ps

module calendar_clock_with_field_edit_top
    import ccfe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [2:0] mode, [7:3] zero
    input  logic [2:0]  s_tuser,   // [2:0] field_select
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // [5:0] seconds_out, [11:6] minutes_out, [16:12] hours_out,
                                   // [21:17] day_out, [25:22] month_out, [39:26] year_out,
                                   // [41:40] carry_level, [42] day_rollover, [47:43] zero
);

    logic req_valid;
    req_t req;
    res_t res;
    logic can_load;
    logic advance;

    // Request moves on when the result register is free
    assign advance = req_valid && can_load;

    ccfe_in_stage u_in (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .advance   (advance),
        .req_valid (req_valid),
        .req       (req)
    );

    ccfe_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .commit (advance),
        .req    (req),
        .res    (res)
    );

    ccfe_out_stage u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (advance),
        .res      (res),
        .can_load (can_load),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

/* rtl/core/ccfe_in_stage.sv */
// Input register stage: holds one accepted request until the core takes it.
`timescale 1ns / 1ps

module ccfe_in_stage
    import ccfe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [2:0] mode, rest zero
    input  logic [2:0] s_tuser,   // [2:0] field_select
    input  logic       advance,
    output logic       req_valid,
    output req_t       req
);

    logic valid_reg;
    logic valid_next;
    req_t req_reg;

    // Free, or emptying this cycle
    assign s_tready = !valid_reg || advance;

    always_comb
    begin
        valid_next = valid_reg;
        if (s_tready)
            valid_next = s_tvalid;
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            req_reg.mode         <= s_tdata[2:0];
            req_reg.field_select <= s_tuser;
        end
    end

    assign req_valid = valid_reg;
    assign req       = req_reg;

endmodule

/* rtl/core/ccfe_core.sv */
// Calendar state registers with tick, step, restore and capture logic.
`timescale 1ns / 1ps

`include "calendar_clock_with_field_edit_top_macros.svh"

module ccfe_core
    import ccfe_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic commit,
    input  req_t req,
    output res_t res
);

    logic [5:0]  sec_reg,  sec_next;
    logic [5:0]  min_reg,  min_next;
    logic [4:0]  hr_reg,   hr_next;
    logic [4:0]  day_reg,  day_next;
    logic [3:0]  mon_reg,  mon_next;
    logic [13:0] yr_reg,   yr_next;
    logic [8:0]  ym_reg,   ym_next;    // year mod 400, kept alongside the year
    logic [13:0] svyr_reg, svyr_next;
    logic [8:0]  svym_reg, svym_next;
    logic [3:0]  svmon_reg, svmon_next;
    logic [4:0]  svday_reg, svday_next;

    logic        up;
    logic [1:0]  level;
    logic [4:0]  nd_cur;
    logic [4:0]  nd_yr;
    logic [4:0]  nd_mon;
    logic [8:0]  ym_inc;
    logic [8:0]  ym_dec;
    logic [13:0] yr_step;
    logic [8:0]  ym_step;
    logic [3:0]  mon_step;
    logic [5:0]  day_step;
    logic [5:0]  hr_wrap;
    logic [5:0]  day_inc;

    // Shared terms
    always_comb
    begin
        up      = (req.mode == MODE_UP);
        ym_inc  = (ym_reg == MOD_TOP) ? 9'd0 : ym_reg + 9'd1;
        ym_dec  = (ym_reg == 9'd0) ? MOD_TOP : ym_reg - 9'd1;
        day_inc = {1'b0, day_reg} + 6'd1;

        // Saturating year step
        yr_step = yr_reg;
        ym_step = ym_reg;
        if (up && (yr_reg < YEAR_MAX))
        begin
            yr_step = yr_reg + 14'd1;
            ym_step = ym_inc;
        end
        else if (!up && (yr_reg != 14'd0))
        begin
            yr_step = yr_reg - 14'd1;
            ym_step = ym_dec;
        end

        if (up)
            mon_step = (mon_reg >= MONTH_TOP) ? 4'd1 : mon_reg + 4'd1;
        else
            mon_step = ((mon_reg <= 4'd1) || (mon_reg > MONTH_TOP)) ? MONTH_TOP
                                                                    : mon_reg - 4'd1;

        if (up)
            day_step = day_inc;
        else
            day_step = (day_reg == 5'd0) ? 6'd0 : {1'b0, day_reg} - 6'd1;

        nd_cur  = month_days(mon_reg, is_leap(ym_reg));
        nd_yr   = month_days(mon_reg, is_leap(ym_step));
        nd_mon  = month_days(mon_step, is_leap(ym_reg));
        hr_wrap = wrap_step({1'b0, hr_reg}, up, HOUR_TOP);
    end

    // Next state per request kind
    always_comb
    begin
        sec_next   = sec_reg;
        min_next   = min_reg;
        hr_next    = hr_reg;
        day_next   = day_reg;
        mon_next   = mon_reg;
        yr_next    = yr_reg;
        ym_next    = ym_reg;
        svyr_next  = svyr_reg;
        svym_next  = svym_reg;
        svmon_next = svmon_reg;
        svday_next = svday_reg;
        level      = LVL_SEC;

        unique case (req.mode) inside
            MODE_TICK:
            begin
                sec_next = sec_reg + 6'd1;
                if (sec_reg >= SEC_TOP)
                begin
                    sec_next = 6'd0;
                    level    = LVL_MIN;
                    min_next = min_reg + 6'd1;
                    if (min_reg >= SEC_TOP)
                    begin
                        min_next = 6'd0;
                        level    = LVL_HOUR;
                        hr_next  = hr_reg + 5'd1;
                        if ({1'b0, hr_reg} >= HOUR_TOP)
                        begin
                            hr_next  = 5'd0;
                            level    = LVL_DAY;
                            day_next = day_inc[4:0];
                            // Month end; restored days past the end land here too
                            if (day_inc > {1'b0, nd_cur})
                            begin
                                day_next = 5'd1;
                                mon_next = mon_reg + 4'd1;
                                if (mon_reg >= MONTH_TOP)
                                begin
                                    mon_next = 4'd1;
                                    if (yr_reg < YEAR_MAX)
                                    begin
                                        yr_next = yr_reg + 14'd1;
                                        ym_next = ym_inc;
                                    end
                                end
                            end
                        end
                    end
                end
            end
            MODE_UP, MODE_DOWN:
            begin
                unique case (req.field_select)
                    FLD_YEAR:
                    begin
                        yr_next  = yr_step;
                        ym_next  = ym_step;
                        day_next = check_day({1'b0, day_reg}, nd_yr);
                    end
                    FLD_MONTH:
                    begin
                        mon_next = mon_step;
                        day_next = check_day({1'b0, day_reg}, nd_mon);
                    end
                    FLD_DAY:     day_next = check_day(day_step, nd_cur);
                    FLD_HOURS:   hr_next  = hr_wrap[4:0];
                    FLD_MIN_LO:  min_next = wrap_step(min_reg, up, SEC_TOP);
                    FLD_MIN_HI:
                    begin
                        sec_next = 6'd0;
                        min_next = wrap_step(min_reg, up, SEC_TOP);
                    end
                    FLD_SECONDS: sec_next = wrap_step(sec_reg, up, SEC_TOP);
                    default:
                    begin
                    end
                endcase
            end
            MODE_RESTORE:
            begin
                unique case (req.field_select) inside
                    FLD_YEAR:
                    begin
                        yr_next = svyr_reg;
                        ym_next = svym_reg;
                    end
                    FLD_MONTH: mon_next = svmon_reg;
                    FLD_DAY:   day_next = svday_reg;
                    FLD_HOURS: hr_next  = 5'd0;
                    FLD_MIN_LO, FLD_MIN_HI:
                    begin
                        sec_next = 6'd0;
                        min_next = 6'd0;
                    end
                    FLD_SECONDS: sec_next = 6'd0;
                    default:
                    begin
                    end
                endcase
            end
            MODE_CAPTURE:
            begin
                svyr_next  = yr_reg;
                svym_next  = ym_reg;
                svmon_next = mon_reg;
                svday_next = day_reg;
            end
            default:
            begin
            end
        endcase
    end

    // Result of the request in hand
    always_comb
    begin
        res.seconds_out  = sec_next;
        res.minutes_out  = min_next;
        res.hours_out    = hr_next;
        res.day_out      = day_next;
        res.month_out    = mon_next;
        res.year_out     = yr_next;
        res.carry_level  = level;
        res.day_rollover = (level == LVL_DAY);
    end

    // State registers, updated when a request is committed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sec_reg   <= RST_SEC;
            min_reg   <= RST_MIN;
            hr_reg    <= RST_HOUR;
            day_reg   <= RST_DAY;
            mon_reg   <= RST_MONTH;
            yr_reg    <= RST_YEAR;
            ym_reg    <= RST_YMOD;
            svyr_reg  <= RST_YEAR;
            svym_reg  <= RST_YMOD;
            svmon_reg <= RST_MONTH;
            svday_reg <= RST_DAY;
        end
        else if (commit)
        begin
            sec_reg   <= sec_next;
            min_reg   <= min_next;
            hr_reg    <= hr_next;
            day_reg   <= day_next;
            mon_reg   <= mon_next;
            yr_reg    <= yr_next;
            ym_reg    <= ym_next;
            svyr_reg  <= svyr_next;
            svym_reg  <= svym_next;
            svmon_reg <= svmon_next;
            svday_reg <= svday_next;
        end
    end

    // Checks
    `CCFE_ASSERT(a_day_nonzero, day_reg != 5'd0, "day of month is zero")
    `CCFE_ASSERT(a_month_range, (mon_reg != 4'd0) && (mon_reg <= MONTH_TOP), "month out of range")
    `CCFE_ASSERT(a_ymod_zero, (yr_reg != 14'd0) || (ym_reg == 9'd0), "year 0 out of leap cycle")
    `CCFE_ASSERT(a_ymod_max, (yr_reg != YEAR_MAX) || (ym_reg == MOD_TOP), "year 9999 out of cycle")
    `CCFE_ASSERT_HOLD(a_hold_year, !commit, yr_reg, "year moved without a commit")

endmodule

/* rtl/core/ccfe_out_stage.sv */
// Result register stage: holds one result until the downstream side takes it.
`timescale 1ns / 1ps

module ccfe_out_stage
    import ccfe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  res_t        res,
    output logic        can_load,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata   // seconds, minutes, hours, day, month, year,
                                  // carry_level, day_rollover, zero fill
);

    logic valid_reg;
    logic valid_next;
    res_t res_reg;

    // Empty, or being taken this cycle
    assign can_load = !valid_reg || m_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (m_tready)
            valid_next = 1'b0;
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= res;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {5'd0, res_reg.day_rollover, res_reg.carry_level, res_reg.year_out,
                       res_reg.month_out, res_reg.day_out, res_reg.hours_out,
                       res_reg.minutes_out, res_reg.seconds_out};

endmodule

/* tb/calendar_clock_with_field_edit_top_test.sv */
// Self-checking testbench of the calendar clock: random handshakes, a predicted calendar, a year sweep.
`timescale 1ns / 1ps

import ccfe_pkg::*;

// Predicted calendar and the queue of readings still due from the block
class calendar_scoreboard;
    logic [5:0]  sec;
    logic [5:0]  min;
    logic [4:0]  hour;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic [13:0] snap_year;
    logic [3:0]  snap_month;
    logic [4:0]  snap_day;
    res_t        predicted_readings[$];
    int          errors;

    function new();
        sec        = 6'd0;
        min        = 6'd59;
        hour       = 5'd23;
        day        = 5'd11;
        month      = 4'd11;
        year       = 14'd1962;
        snap_year  = 14'd1962;
        snap_month = 4'd11;
        snap_day   = 5'd11;
        errors     = 0;
    endfunction

    // Full Gregorian rule; year zero counts as divisible by 400
    function bit gregorian_leap(int y);
        return ((y % 4) == 0 && (y % 100) != 0) || ((y % 400) == 0);
    endfunction

    function int month_length();
        int n;
        case (month) inside
            4'd2:                     n = gregorian_leap(int'(year)) ? 29 : 28;
            4'd4, 4'd6, 4'd9, 4'd11:  n = 30;
            default:                  n = 31;
        endcase
        return n;
    endfunction

    // Past the month end gives day 1, below 1 gives the last day
    function void settle_day(int d);
        int n;
        n = month_length();
        if (d > n)
            d = 1;
        if (d < 1)
            d = n;
        day = 5'(d);
    endfunction

    function int wrap_count(int v, bit up, int top);
        if (up)
            return (v >= top) ? 0 : v + 1;
        return (v == 0 || v > top) ? top : v - 1;
    endfunction

    // Midnight carry into the day, month and year; year holds at 9999
    function void next_day();
        int d;
        d = int'(day) + 1;
        if (d > month_length()) begin
            d = 1;
            if (month >= 4'd12) begin
                month = 4'd1;
                if (year < 14'd9999)
                    year = year + 14'd1;
            end
            else
                month = month + 4'd1;
        end
        day = 5'(d);
    endfunction

    function void step_field(logic [2:0] sel, bit up);
        case (sel)
            FLD_YEAR:
            begin
                if (up && year < 14'd9999)
                    year = year + 14'd1;
                else if (!up && year > 14'd0)
                    year = year - 14'd1;
                settle_day(int'(day));
            end
            FLD_MONTH:
            begin
                if (up)
                    month = (month >= 4'd12) ? 4'd1 : month + 4'd1;
                else
                    month = (month <= 4'd1 || month > 4'd12) ? 4'd12 : month - 4'd1;
                settle_day(int'(day));
            end
            FLD_DAY:     settle_day(up ? int'(day) + 1 : (day == 5'd0 ? 0 : int'(day) - 1));
            FLD_HOURS:   hour = 5'(wrap_count(int'(hour), up, 23));
            FLD_MIN_LO:  min = 6'(wrap_count(int'(min), up, 59));
            FLD_MIN_HI:
            begin
                sec = 6'd0;
                min = 6'(wrap_count(int'(min), up, 59));
            end
            FLD_SECONDS: sec = 6'(wrap_count(int'(sec), up, 59));
            default:     ;
        endcase
    endfunction

    function void restore_field(logic [2:0] sel);
        case (sel) inside
            FLD_YEAR:    year = snap_year;
            FLD_MONTH:   month = snap_month;
            FLD_DAY:     day = snap_day;
            FLD_HOURS:   hour = 5'd0;
            FLD_MIN_LO, FLD_MIN_HI:
            begin
                sec = 6'd0;
                min = 6'd0;
            end
            FLD_SECONDS: sec = 6'd0;
            default:     ;
        endcase
    endfunction

    // Apply one accepted request and queue the reading it should produce
    function void note_request(logic [2:0] mode, logic [2:0] sel);
        logic [1:0] lvl;
        res_t       r;
        lvl = LVL_SEC;
        case (mode)
            MODE_TICK:
            begin
                if (sec >= 6'd59) begin
                    sec = 6'd0;
                    lvl = LVL_MIN;
                    if (min >= 6'd59) begin
                        min = 6'd0;
                        lvl = LVL_HOUR;
                        if (hour >= 5'd23) begin
                            hour = 5'd0;
                            lvl  = LVL_DAY;
                            next_day();
                        end
                        else
                            hour = hour + 5'd1;
                    end
                    else
                        min = min + 6'd1;
                end
                else
                    sec = sec + 6'd1;
            end
            MODE_UP:      step_field(sel, 1'b1);
            MODE_DOWN:    step_field(sel, 1'b0);
            MODE_RESTORE: restore_field(sel);
            MODE_CAPTURE:
            begin
                snap_year  = year;
                snap_month = month;
                snap_day   = day;
            end
            default:      ;
        endcase
        r.seconds_out  = sec;
        r.minutes_out  = min;
        r.hours_out    = hour;
        r.day_out      = day;
        r.month_out    = month;
        r.year_out     = year;
        r.carry_level  = lvl;
        r.day_rollover = (lvl == LVL_DAY);
        predicted_readings.push_back(r);
    endfunction

    function int field_value(logic [2:0] sel);
        case (sel) inside
            FLD_YEAR:               return int'(year);
            FLD_MONTH:              return int'(month);
            FLD_DAY:                return int'(day);
            FLD_HOURS:              return int'(hour);
            FLD_MIN_LO, FLD_MIN_HI: return int'(min);
            default:                return int'(sec);
        endcase
    endfunction

    function int pending();
        return predicted_readings.size();
    endfunction

    task report_mismatch(string what, int got, int want);
        $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        errors++;
    endtask

    task compare_field(string what, int got, int want);
        if (got != want)
            report_mismatch(what, got, want);
    endtask

    // Compare one accepted reading with the oldest prediction
    task check_reading(logic [47:0] word);
        res_t e;
        if (predicted_readings.size() == 0) begin
            report_mismatch("reading with no request outstanding", int'(word[39:26]), -1);
            return;
        end
        e = predicted_readings.pop_front();
        compare_field("seconds", int'(word[5:0]), int'(e.seconds_out));
        compare_field("minutes", int'(word[11:6]), int'(e.minutes_out));
        compare_field("hours", int'(word[16:12]), int'(e.hours_out));
        compare_field("day", int'(word[21:17]), int'(e.day_out));
        compare_field("month", int'(word[25:22]), int'(e.month_out));
        compare_field("year", int'(word[39:26]), int'(e.year_out));
        compare_field("carry level", int'(word[41:40]), int'(e.carry_level));
        compare_field("day rollover", int'(word[42]), int'(e.day_rollover));
    endtask
endclass

module calendar_clock_with_field_edit_top_test;

    // Mode codes the block treats as no-ops, and a field code that selects no field
    localparam logic [2:0] MODE_SPARE0 = 3'd5;
    localparam logic [2:0] MODE_SPARE1 = 3'd6;
    localparam logic [2:0] MODE_SPARE2 = 3'd7;
    localparam logic [2:0] FLD_NONE    = 3'd7;

    localparam int LONG_MONTHS [7] = '{1, 3, 5, 7, 8, 10, 12};

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [7:0]  s_tdata  = 8'd0;
    logic [2:0]  s_tuser  = 3'd0;
    logic        m_tready = 1'b0;
    logic        s_tready;
    logic        m_tvalid;
    logic [47:0] m_tdata;

    bit                 steady = 1'b0;
    int                 sent   = 0;
    calendar_scoreboard sb;

    always #2 clk = ~clk;

    calendar_clock_with_field_edit_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Hard stop if the run hangs
    initial
    begin
        #10_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // Present one request after a random gap and hold it until taken
    task automatic send_request(input logic [2:0] mode, input logic [2:0] sel);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'd0, mode};
        s_tuser  <= sel;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_request(mode, sel);
        sent++;
    endtask

    // Walk a field one step at a time towards a value
    task automatic steer(input logic [2:0] sel, input int target);
        int guard;
        guard = 0;
        while (sb.field_value(sel) != target && guard < 64) begin
            send_request((sb.field_value(sel) < target) ? MODE_UP : MODE_DOWN, sel);
            guard++;
        end
    endtask

    // Jump to the last seconds of the minute; minutes_too and hours_too also set minute 59 and hour 23
    task automatic near_midnight(input bit hours_too, input bit minutes_too);
        logic [2:0] min_sel;
        min_sel = $urandom_range(0, 1) ? FLD_MIN_LO : FLD_MIN_HI;
        if (hours_too) begin
            send_request(MODE_RESTORE, FLD_HOURS);
            send_request(MODE_DOWN, FLD_HOURS);
        end
        if (minutes_too) begin
            send_request(MODE_RESTORE, min_sel);
            send_request(MODE_DOWN, min_sel);
        end
        send_request(MODE_RESTORE, FLD_SECONDS);
        send_request(MODE_DOWN, FLD_SECONDS);
        repeat ($urandom_range(0, 3)) send_request(MODE_DOWN, FLD_SECONDS);
    endtask

    task automatic send_ticks(input int n);
        repeat (n) send_request(MODE_TICK, 3'($urandom_range(0, 7)));
    endtask

    // Field extremes, every request kind and the no-op codes
    task automatic directed_requests();
        send_request(MODE_DOWN, FLD_SECONDS);
        send_request(MODE_TICK, FLD_YEAR);
        send_request(MODE_DOWN, FLD_MIN_LO);
        send_request(MODE_DOWN, FLD_SECONDS);
        send_request(MODE_TICK, FLD_NONE);
        send_request(MODE_UP, FLD_MIN_HI);
        send_request(MODE_UP, FLD_SECONDS);
        send_request(MODE_DOWN, FLD_MIN_HI);
        send_request(MODE_DOWN, FLD_HOURS);
        send_request(MODE_DOWN, FLD_HOURS);
        send_request(MODE_UP, FLD_HOURS);
        send_request(MODE_UP, FLD_MONTH);
        send_request(MODE_UP, FLD_MONTH);
        send_request(MODE_DOWN, FLD_DAY);
        send_request(MODE_UP, FLD_YEAR);
        send_request(MODE_CAPTURE, FLD_NONE);
        send_request(MODE_DOWN, FLD_YEAR);
        send_request(MODE_RESTORE, FLD_YEAR);
        send_request(MODE_RESTORE, FLD_MONTH);
        send_request(MODE_RESTORE, FLD_DAY);
        send_request(MODE_RESTORE, FLD_HOURS);
        send_request(MODE_RESTORE, FLD_MIN_LO);
        send_request(MODE_RESTORE, FLD_MIN_HI);
        send_request(MODE_RESTORE, FLD_SECONDS);
        send_request(MODE_RESTORE, FLD_NONE);
        send_request(MODE_UP, FLD_NONE);
        send_request(MODE_DOWN, FLD_NONE);
        send_request(MODE_SPARE0, FLD_DAY);
        send_request(MODE_SPARE1, FLD_NONE);
        send_request(MODE_SPARE2, FLD_SECONDS);
    endtask

    // Random scenarios: carries, month ends, snapshots, over-long days and loose noise
    task automatic random_requests(input int quota);
        int first;
        int k;
        first = sent;
        while (sent - first < quota) begin
            steady = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 5)) inside
                0, 1:
                begin
                    repeat ($urandom_range(1, 8))
                        send_request(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)));
                end
                2:
                begin
                    near_midnight(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                    send_ticks($urandom_range(1, 8));
                end
                3:
                begin
                    k = int'(sb.year) + int'($urandom_range(0, 8)) - 4;
                    steer(FLD_YEAR, (k < 0) ? 0 : k);
                    steer(FLD_MONTH, $urandom_range(1, 12));
                    // day 1 stepped down lands on the last day of the month
                    steer(FLD_DAY, 1);
                    send_request(MODE_DOWN, FLD_DAY);
                    if ($urandom_range(0, 2) == 0)
                        send_request(MODE_DOWN, FLD_DAY);
                    near_midnight(1'b1, 1'b1);
                    send_ticks(4);
                    if ($urandom_range(0, 1))
                        send_request(MODE_DOWN, FLD_DAY);
                end
                4:
                begin
                    send_request(MODE_CAPTURE, 3'($urandom_range(0, 7)));
                    repeat ($urandom_range(1, 4))
                        send_request(3'($urandom_range(MODE_UP, MODE_DOWN)),
                                     3'($urandom_range(FLD_YEAR, FLD_DAY)));
                    repeat ($urandom_range(1, 3))
                        send_request(MODE_RESTORE, 3'($urandom_range(0, 7)));
                end
                default:
                begin
                    // snapshot of day 31, then restore it into a neighbouring month, which may be shorter
                    steer(FLD_MONTH, LONG_MONTHS[$urandom_range(0, 6)]);
                    steer(FLD_DAY, 1);
                    send_request(MODE_DOWN, FLD_DAY);
                    send_request(MODE_CAPTURE, 3'($urandom_range(0, 7)));
                    send_request($urandom_range(0, 1) ? MODE_UP : MODE_DOWN, FLD_MONTH);
                    send_request(MODE_RESTORE, FLD_DAY);
                    if ($urandom_range(0, 1)) begin
                        near_midnight(1'b1, 1'b1);
                        send_ticks(4);
                    end
                    else
                        send_request($urandom_range(0, 1) ? MODE_UP : MODE_DOWN,
                                     3'($urandom_range(FLD_YEAR, FLD_DAY)));
                end
            endcase
        end
        steady = 1'b0;
    endtask

    // Walk the year to a target, each year on the way showing its February length
    task automatic year_sweep(input int target);
        steer(FLD_MONTH, 2);
        steer(FLD_DAY, 1);
        send_request(MODE_CAPTURE, 3'($urandom_range(0, 7)));
        while (int'(sb.year) != target) begin
            steady = ($urandom_range(0, 3) == 0);
            send_request((int'(sb.year) < target) ? MODE_UP : MODE_DOWN, FLD_YEAR);
            send_request(MODE_RESTORE, FLD_DAY);
            send_request(MODE_DOWN, FLD_DAY);
        end
        steady = 1'b0;

        // 2000 is leap: 28 Feb rolls into the 29th
        steer(FLD_DAY, 28);
        near_midnight(1'b1, 1'b1);
        send_ticks(4);
    endtask

    // Result side: random stalls, each reading checked on acceptance
    initial
    begin : reading_sink
        int stall;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            stall = steady ? 0 : $urandom_range(0, 4);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            sb.check_reading(m_tdata);
        end
    end

    // Reset, stimulus, drain and verdict
    initial
    begin : stimulus
        sb = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        directed_requests();
        random_requests(250);
        year_sweep(2000);
        random_requests(200);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
